// ----- rtl/core/fsr_pkg.sv -----
// shared constants and types for the fsr force converter
package fsr_pkg;

    // defaults for the top level parameters
    localparam int CHANNELS_DEF = 8;
    localparam int ADC_BITS_DEF = 10;

    // register widths and reset value
    localparam int PULL_W     = 20;
    localparam int APB_W      = 32;
    localparam logic [PULL_W-1:0] PULL_RESET = 20'd10000;

    // resistance and quotient widths
    localparam int RES_W = 16;
    localparam int QW    = RES_W + 1;
    localparam int FORCE_W = 20;

    // curve coefficient widths
    localparam int AW = 17;
    localparam int BW = 26;
    localparam int CW = 33;
    localparam int GW = 20;

    // curve segment limits in ohm
    localparam logic [RES_W-1:0] SEG1_LIM = 16'd300;
    localparam logic [RES_W-1:0] SEG2_LIM = 16'd750;
    localparam logic [RES_W-1:0] SEG3_LIM = 16'd1500;

    // q16 coefficients, curve is a*r*r - b*r + c
    localparam logic [AW-1:0] COEF_A1 = 17'd56433;
    localparam logic [BW-1:0] COEF_B1 = 26'd34332344;
    localparam logic [CW-1:0] COEF_C1 = 33'd5424349184;
    localparam logic [AW-1:0] COEF_A2 = 17'd1402;
    localparam logic [BW-1:0] COEF_B2 = 26'd1739588;
    localparam logic [CW-1:0] COEF_C2 = 33'd561623859;
    localparam logic [AW-1:0] COEF_A3 = 17'd33;
    localparam logic [BW-1:0] COEF_B3 = 26'd96757;
    localparam logic [CW-1:0] COEF_C3 = 33'd79849062;
    localparam logic [BW-1:0] COEF_B4 = 26'd9227;
    localparam logic [CW-1:0] COEF_C4 = 33'd24878121;

    // output gain 9.98 in q16
    localparam logic [GW-1:0] GAIN_Q16 = 20'd654049;

    // per stage control travelling with each word
    typedef struct packed {
        logic valid;
        logic open;
    } t_ctl;

endpackage

// ----- rtl/core/fsr_in_if.sv -----
// input channel carrying channel number and converter sample
interface fsr_in_if #(
    parameter int CH_W = 3,
    parameter int AB   = 10
) ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic [AB-1:0]   adc_code;

    modport source(output valid, channel, adc_code, input ready);
    modport sink(input valid, channel, adc_code, output ready);
endinterface

// ----- rtl/core/fsr_out_if.sv -----
// output channel carrying channel number and force
interface fsr_out_if #(
    parameter int CH_W = 3
) ();
    logic                         valid;
    logic                         ready;
    logic [CH_W-1:0]              channel_out;
    logic [fsr_pkg::FORCE_W-1:0]  force_mn;

    modport source(output valid, channel_out, force_mn, input ready);
    modport sink(input valid, channel_out, force_mn, output ready);
endinterface

// ----- rtl/core/fsr_adc_to_force.sv -----
// fsr force converter: divider resistance and piecewise force curve
// pipeline: 1 input stage, 17 divider cells and 5 curve stages,
// the last one the output register
// throughput: one word per cycle, the whole pipe stalls only while the
// output word waits; reset clears all valid flags and loads 10000 ohm
module fsr_adc_to_force #(
    parameter int CHANNELS = fsr_pkg::CHANNELS_DEF,
    parameter int ADC_BITS = fsr_pkg::ADC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [0:0]                paddr,
    input  logic [fsr_pkg::APB_W-1:0] pwdata,
    output logic [fsr_pkg::APB_W-1:0] prdata,
    output logic                      pready,
    fsr_in_if.sink                    i_in,
    fsr_out_if.source                 o_out
);
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW  = fsr_pkg::PULL_W + ADC_BITS;
    localparam int NC  = fsr_pkg::QW;
    localparam logic [ADC_BITS-1:0] FULL = '1;

    logic [fsr_pkg::PULL_W-1:0] r_pull;
    logic                       w_en;
    fsr_pkg::t_ctl              r_ctl0;
    logic [CHW-1:0]             r_ch0;
    logic [NW-1:0]              r_num;
    logic [ADC_BITS-1:0]        r_den;

    fsr_pkg::t_ctl              w_ctl  [0:NC];
    logic [CHW-1:0]             w_chan [0:NC];
    logic [NW-1:0]              w_rem  [0:NC];
    logic [ADC_BITS-1:0]        w_den  [0:NC];
    logic [fsr_pkg::QW-1:0]     w_q    [0:NC];
    fsr_pkg::t_ctl              w_octl;

    // config register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pull <= fsr_pkg::PULL_RESET;
        end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
            r_pull <= pwdata[fsr_pkg::PULL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? fsr_pkg::APB_W'(r_pull) : '0;

    // pipe advances unless the output word is held
    assign w_en       = !w_octl.valid || o_out.ready;
    assign i_in.ready = w_en;

    // input stage: numerator and divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_en) begin
            r_ctl0.valid <= i_in.valid;
            r_ctl0.open  <= (i_in.adc_code == FULL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ch0  <= i_in.channel;
            r_num  <= NW'(r_pull) * NW'(i_in.adc_code);
            r_den  <= FULL - i_in.adc_code;
        end
    end

    assign w_ctl[0]  = r_ctl0;
    assign w_chan[0] = r_ch0;
    assign w_rem[0]  = r_num;
    assign w_den[0]  = r_den;
    assign w_q[0]    = '0;

    // divider cell row, top bit flags saturation
    for (genvar g = 0; g < NC; g++) begin : g_cell
        fsr_cell #(
            .NW   (NW),
            .DW   (ADC_BITS),
            .CHW  (CHW),
            .SHIFT(NC - 1 - g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (w_ctl[g]),
            .i_chan (w_chan[g]),
            .i_rem  (w_rem[g]),
            .i_den  (w_den[g]),
            .i_q    (w_q[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_chan (w_chan[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_den  (w_den[g+1]),
            .o_q    (w_q[g+1])
        );
    end

    // force curve and output register
    fsr_poly #(
        .CHW(CHW)
    ) u_poly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (w_ctl[NC]),
        .i_chan (w_chan[NC]),
        .i_q    (w_q[NC]),
        .o_ctl  (w_octl),
        .o_chan (o_out.channel_out),
        .o_force(o_out.force_mn)
    );

    assign o_out.valid = w_octl.valid;
endmodule

// ----- rtl/core/fsr_cell.sv -----
// one restoring divider cell, resolves a single quotient bit per word
module fsr_cell #(
    parameter int NW    = 30,
    parameter int DW    = 10,
    parameter int CHW   = 3,
    parameter int SHIFT = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  fsr_pkg::t_ctl           i_ctl,
    input  logic [CHW-1:0]          i_chan,
    input  logic [NW-1:0]           i_rem,
    input  logic [DW-1:0]           i_den,
    input  logic [fsr_pkg::QW-1:0]  i_q,
    output fsr_pkg::t_ctl           o_ctl,
    output logic [CHW-1:0]          o_chan,
    output logic [NW-1:0]           o_rem,
    output logic [DW-1:0]           o_den,
    output logic [fsr_pkg::QW-1:0]  o_q
);
    fsr_pkg::t_ctl          r_ctl;
    logic [CHW-1:0]         r_chan;
    logic [NW-1:0]          r_rem, n_rem;
    logic [DW-1:0]          r_den;
    logic [fsr_pkg::QW-1:0] r_q, n_q;
    logic [NW-1:0]          w_dsh;
    logic                   w_ge;

    // trial subtract of the shifted divisor
    always_comb begin
        w_dsh = NW'(i_den) << SHIFT;
        w_ge  = (i_rem >= w_dsh);
        n_rem = w_ge ? (i_rem - w_dsh) : i_rem;
        n_q   = w_ge ? (i_q | (fsr_pkg::QW'(1) << SHIFT)) : i_q;
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= i_chan;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_q    <= n_q;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_chan = r_chan;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_q    = r_q;
endmodule

// ----- rtl/core/fsr_poly.sv -----
// piecewise force curve, gain, rounding and output register
module fsr_poly #(
    parameter int CHW = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  fsr_pkg::t_ctl                 i_ctl,
    input  logic [CHW-1:0]                i_chan,
    input  logic [fsr_pkg::QW-1:0]        i_q,
    output fsr_pkg::t_ctl                 o_ctl,
    output logic [CHW-1:0]                o_chan,
    output logic [fsr_pkg::FORCE_W-1:0]   o_force
);
    localparam int RW  = fsr_pkg::RES_W;
    localparam int R2W = 2 * RW;
    localparam int ARW = fsr_pkg::AW + R2W;
    localparam int BRW = fsr_pkg::BW + RW;
    localparam int PW  = ARW + 2;
    localparam int MW  = fsr_pkg::CW + fsr_pkg::GW;

    fsr_pkg::t_ctl            r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic [CHW-1:0]           r_ch1, r_ch2, r_ch3, r_ch4, r_ch5;
    logic [RW-1:0]            w_r, r_r;
    logic [fsr_pkg::AW-1:0]   w_a, r_a;
    logic [fsr_pkg::BW-1:0]   w_b, r_b;
    logic [fsr_pkg::CW-1:0]   w_c, r_c1, r_c2;
    logic [R2W-1:0]           r_r2;
    logic [ARW-1:0]           r_ar2;
    logic [BRW-1:0]           r_br;
    logic signed [PW-1:0]     w_p;
    logic                     r_pos, r_pos4;
    logic [fsr_pkg::CW-1:0]   r_p;
    logic [MW-1:0]            r_prod;
    logic [MW:0]              w_rnd;
    logic [MW-32:0]           w_f;
    logic [fsr_pkg::FORCE_W-1:0] w_force, r_force;

    // saturate resistance and pick the curve segment
    always_comb begin
        w_r = i_q[fsr_pkg::QW-1] ? '1 : i_q[RW-1:0];
        if (w_r < fsr_pkg::SEG1_LIM) begin
            w_a = fsr_pkg::COEF_A1;
            w_b = fsr_pkg::COEF_B1;
            w_c = fsr_pkg::COEF_C1;
        end else if (w_r < fsr_pkg::SEG2_LIM) begin
            w_a = fsr_pkg::COEF_A2;
            w_b = fsr_pkg::COEF_B2;
            w_c = fsr_pkg::COEF_C2;
        end else if (w_r < fsr_pkg::SEG3_LIM) begin
            w_a = fsr_pkg::COEF_A3;
            w_b = fsr_pkg::COEF_B3;
            w_c = fsr_pkg::COEF_C3;
        end else begin
            w_a = '0;
            w_b = fsr_pkg::COEF_B4;
            w_c = fsr_pkg::COEF_C4;
        end
    end

    // polynomial sum, rounding and clamp
    always_comb begin
        w_p = $signed({2'b00, r_ar2}) - $signed(PW'(r_br)) + $signed(PW'(r_c2));
        w_rnd = {1'b0, r_prod} + ((MW + 1)'(1) << 31);
        w_f = w_rnd[MW:32];
        if (!r_pos4 || r_ctl4.open) begin
            w_force = '0;
        end else if (|w_f[MW-32:fsr_pkg::FORCE_W]) begin
            w_force = '1;
        end else begin
            w_force = w_f[fsr_pkg::FORCE_W-1:0];
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
        end
    end

    // stage payload: square, products, sum, gain, output
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ch1   <= i_chan;
            r_r     <= w_r;
            r_r2    <= R2W'(w_r) * R2W'(w_r);
            r_a     <= w_a;
            r_b     <= w_b;
            r_c1    <= w_c;
            r_ch2   <= r_ch1;
            r_ar2   <= ARW'(r_a) * ARW'(r_r2);
            r_br    <= BRW'(r_b) * BRW'(r_r);
            r_c2    <= r_c1;
            r_ch3   <= r_ch2;
            r_pos   <= (w_p > 0);
            r_p     <= w_p[fsr_pkg::CW-1:0];
            r_ch4   <= r_ch3;
            r_pos4  <= r_pos;
            r_prod  <= MW'(r_p) * MW'(fsr_pkg::GAIN_Q16);
            r_ch5   <= r_ch4;
            r_force <= w_force;
        end
    end

    assign o_ctl   = r_ctl5;
    assign o_chan  = r_ch5;
    assign o_force = r_force;
endmodule
